// ----- rtl/cpac_pkg.sv -----
// Shared types and constants for the memory-pack port engine.
// No dependencies; compiled first.
`default_nettype none

package cpac_pkg;

   // Block geometry and address decoding
   localparam int unsigned BLOCK_BYTES = 32;
   localparam int unsigned COUNT_W     = 5;
   localparam logic [15:0] ADDR_SPECIAL = 16'h8001;
   localparam logic [15:0] ADDR_ALIGN   = 16'hFFE0;
   localparam logic [15:0] ADDR_TOP     = 16'h7FE0;

   // Width used to build a flat store index before it is cut to the RAM width
   localparam int unsigned IDX_CALC_W = 18;

   // CRC-8, MSB first
   localparam logic [7:0] CRC_POLY = 8'h85;

   // Configuration register indexes
   localparam logic CSR_PRESENT_MASK = 1'b0;
   localparam logic CSR_PAK_MASK     = 1'b1;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_CLEAR   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_RD_ADDR = 5'b00100,
      ST_RD_DATA = 5'b01000,
      ST_FINAL   = 5'b10000
   } state_type;

   // Operation codes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/cpac_if.sv -----
// Valid/ready channel interfaces for request and response transactions.
// No dependencies.
`default_nettype none

interface cpac_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [1:0]  port;
   logic [15:0] address;
   logic [7:0]  data_byte;

   modport source (output valid, output operation, output port, output address,
                   output data_byte, input ready);
   modport sink   (input valid, input operation, input port, input address,
                   input data_byte, output ready);
endinterface

interface cpac_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic       is_crc;
   logic       last;
   logic       no_device;

   modport source (output valid, output byte_out, output is_crc, output last,
                   output no_device, input ready);
   modport sink   (input valid, input byte_out, input is_crc, input last,
                   input no_device, output ready);
endinterface

`default_nettype wire

// ----- rtl/controller_pack_access_crc_unit.sv -----
// Memory-pack port engine: 32-byte block reads and writes with a CRC-8 answer.
// Depends on cpac_pkg, cpac_if, cpac_ram and cpac_crc_step.
//
// After reset the block sweeps the pack store to zero, one byte per cycle, over
// all PORT_COUNT*PACK_BYTES bytes (131072 by default) before it takes a request;
// configuration writes are taken throughout. A write data transaction is taken
// while the block is idle; the 32nd one then emits its CRC from a final state. A
// read sends its 32 bytes and then the CRC, and output stalls hold it up; each
// byte goes through the single registered RAM read port and the shared CRC byte
// step in turn. An absent port answers with one no_device response. Only one
// command is worked on at a time.
`default_nettype none

module controller_pack_access_crc_unit
   import cpac_pkg::*;
#(
   parameter int unsigned PACK_BYTES = 32768,
   parameter int unsigned PORT_COUNT = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_index,
   input  wire logic [3:0] csr_write_data,
   cpac_req_if.sink        req_chan,
   cpac_rsp_if.source      rsp_chan
);

   localparam int unsigned MEM_DEPTH = PORT_COUNT * PACK_BYTES;
   localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
   localparam logic [MEM_AW-1:0] CLEAR_LAST = MEM_AW'(MEM_DEPTH - 1);

   // Registers
   state_type          state_ff, state_in;
   logic [3:0]         present_ff, present_in;
   logic [3:0]         pak_ff, pak_in;
   logic [7:0]         crc_ff, crc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        base_ff, base_in;
   logic [1:0]         wport_ff, wport_in;
   logic               src_ff, src_in;
   logic               nodev_ff, nodev_in;
   logic [MEM_AW-1:0]  clr_ff, clr_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_is_crc_ff, out_is_crc_in;
   logic               out_last_ff, out_last_in;
   logic               out_nodev_ff, out_nodev_in;

   // Datapath nets
   logic              req_take, out_free, first_byte;
   logic [1:0]        eff_port;
   logic [15:0]       eff_addr;
   logic [7:0]        rd_data, rd_byte;
   logic [7:0]        step_crc, step_data, step_out;
   logic              ram_we;
   logic [MEM_AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]        ram_wdata;

   function automatic logic port_ok(input logic [1:0] p, input logic [3:0] mask);
      return (3'(p) < 3'(PORT_COUNT)) && mask[p];
   endfunction

   function automatic logic block_stored(input logic [15:0] raw);
      logic [15:0] a;
      a = raw & ADDR_ALIGN;
      return (raw != ADDR_SPECIAL) && (a <= ADDR_TOP) &&
             ({1'b0, a} + 17'(BLOCK_BYTES) <= 17'(PACK_BYTES));
   endfunction

   function automatic logic [MEM_AW-1:0] store_idx(input logic [1:0] p,
                                                   input logic [15:0] raw,
                                                   input logic [COUNT_W-1:0] cnt);
      logic [IDX_CALC_W-1:0] full;
      full = IDX_CALC_W'(p) * IDX_CALC_W'(PACK_BYTES) + IDX_CALC_W'(raw & ADDR_ALIGN)
             + IDX_CALC_W'(cnt);
      return full[MEM_AW-1:0];
   endfunction

   // Handshake
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign out_free       = !out_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.byte_out  = out_byte_ff;
   assign rsp_chan.is_crc    = out_is_crc_ff;
   assign rsp_chan.last      = out_last_ff;
   assign rsp_chan.no_device = out_nodev_ff;

   // Write command context: first byte latches port and address
   assign first_byte = (count_ff == '0);
   assign eff_port   = first_byte ? req_chan.port : wport_ff;
   assign eff_addr   = first_byte ? req_chan.address : base_ff;
   assign rd_byte    = src_ff ? rd_data : 8'h00;

   // Shared CRC step input selection
   always_comb begin
      step_crc  = crc_ff;
      step_data = 8'h00;
      case (state_ff)
         ST_IDLE: begin
            step_crc  = first_byte ? 8'h00 : crc_ff;
            step_data = req_chan.data_byte;
         end
         ST_RD_DATA: step_data = rd_byte;
         default:    step_data = 8'h00;
      endcase
   end

   cpac_crc_step u_crc_step (
      .crc_in  (step_crc),
      .data_in (step_data),
      .crc_out (step_out)
   );

   // Store access: clearing sweep or write data transaction
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = 8'h00;
      if (state_ff == ST_CLEAR) begin
         ram_we = 1'b1;
      end else if (req_take && req_chan.operation == OP_WRITE) begin
         ram_we    = port_ok(eff_port, present_ff) && port_ok(eff_port, pak_ff) &&
                     block_stored(eff_addr);
         ram_waddr = store_idx(eff_port, eff_addr, count_ff);
         ram_wdata = req_chan.data_byte;
      end
   end

   assign ram_raddr = store_idx(wport_ff, base_ff, count_ff);

   cpac_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_store (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (ram_wdata),
      .read_addr    (ram_raddr),
      .read_data    (rd_data)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      present_in    = present_ff;
      pak_in        = pak_ff;
      crc_in        = crc_ff;
      count_in      = count_ff;
      base_in       = base_ff;
      wport_in      = wport_ff;
      src_in        = src_ff;
      nodev_in      = nodev_ff;
      clr_in        = clr_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_byte_in   = out_byte_ff;
      out_is_crc_in = out_is_crc_ff;
      out_last_in   = out_last_ff;
      out_nodev_in  = out_nodev_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_PRESENT_MASK: present_in = csr_write_data;
            CSR_PAK_MASK:     pak_in     = csr_write_data;
            default:          present_in = present_ff;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               if (req_chan.operation == OP_READ) begin
                  // read abandons any pending write
                  count_in = '0;
                  crc_in   = 8'h00;
                  base_in  = req_chan.address;
                  wport_in = req_chan.port;
                  src_in   = port_ok(req_chan.port, pak_ff) &&
                             block_stored(req_chan.address);
                  if (!port_ok(req_chan.port, present_ff)) begin
                     nodev_in = 1'b1;
                     state_in = ST_FINAL;
                  end else begin
                     state_in = ST_RD_ADDR;
                  end
               end else begin
                  base_in  = eff_addr;
                  wport_in = eff_port;
                  crc_in   = step_out;
                  count_in = count_ff + 1'b1;
                  if (count_ff == COUNT_W'(BLOCK_BYTES - 1)) begin
                     nodev_in = !port_ok(eff_port, present_ff);
                     state_in = ST_FINAL;
                  end
               end
            end
         end
         ST_RD_ADDR: begin
            // address is presented now; move on once the output slot is free
            if (out_free) begin
               state_in = ST_RD_DATA;
            end
         end
         ST_RD_DATA: begin
            out_valid_in  = 1'b1;
            out_byte_in   = rd_byte;
            out_is_crc_in = 1'b0;
            out_last_in   = 1'b0;
            out_nodev_in  = 1'b0;
            crc_in        = step_out;
            count_in      = count_ff + 1'b1;
            if (count_ff == COUNT_W'(BLOCK_BYTES - 1)) begin
               nodev_in = 1'b0;
               state_in = ST_FINAL;
            end else begin
               state_in = ST_RD_ADDR;
            end
         end
         ST_FINAL: begin
            // CRC flush with eight zero bits, or the no_device answer
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_byte_in   = nodev_ff ? 8'h00 : step_out;
               out_is_crc_in = !nodev_ff;
               out_last_in   = 1'b1;
               out_nodev_in  = nodev_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         present_ff   <= 4'h0;
         pak_ff       <= 4'h0;
         crc_ff       <= 8'h00;
         count_ff     <= '0;
         base_ff      <= 16'h0000;
         wport_ff     <= 2'd0;
         src_ff       <= 1'b0;
         nodev_ff     <= 1'b0;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         pak_ff       <= pak_in;
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         base_ff      <= base_in;
         wport_ff     <= wport_in;
         src_ff       <= src_in;
         nodev_ff     <= nodev_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_is_crc_ff <= out_is_crc_in;
      out_last_ff   <= out_last_in;
      out_nodev_ff  <= out_nodev_in;
   end

   // A read byte is only loaded into an empty output slot
   a_rd_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD_DATA |-> !out_valid_ff)
      else $error("read byte would overwrite a pending response");

   // Store writes come only from the clearing sweep or a write transaction
   a_store_write_src: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR) ||
                 (req_take && req_chan.operation == OP_WRITE))
      else $error("unexpected store write");

   // A no_device response carries a zero byte and ends the command
   a_nodev_form: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_nodev_ff |-> out_byte_ff == 8'h00 && out_last_ff &&
                                       !out_is_crc_ff)
      else $error("malformed no_device response");

   // Leaving the final state always leaves a last response behind
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINAL && out_free |=> out_valid_ff && out_last_ff)
      else $error("final response missing");

endmodule

`default_nettype wire

// ----- rtl/cpac_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cpac_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data <= mem_ff[read_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/cpac_crc_step.sv -----
// CRC-8 byte step: shifts eight data bits, MSB first, through the register.
// Depends on cpac_pkg.
`default_nettype none

module cpac_crc_step
   import cpac_pkg::*;
(
   input  wire logic [7:0] crc_in,
   input  wire logic [7:0] data_in,
   output logic      [7:0] crc_out
);

   // One bit per step, feedback from the top bit
   always_comb begin
      logic [7:0] c;
      logic       fb;
      c = crc_in;
      for (int b = 0; b < 8; b++) begin
         fb = c[7];
         c  = {c[6:0], data_in[7-b]};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      crc_out = c;
   end

endmodule

`default_nettype wire

// ----- verif/controller_pack_access_crc_unit_tb.sv -----
// Self-checking bench for the memory-pack port engine: block reads and writes
// with CRC-8 answers, checked against an in-bench copy of the pack store.
// Depends on cpac_pkg, cpac_if and the RTL of controller_pack_access_crc_unit.

module controller_pack_access_crc_unit_tb;
   import cpac_pkg::*;

   localparam int unsigned PACK_BYTES    = 32768;
   localparam int unsigned PORT_COUNT    = 4;
   // long enough for a whole read to finish, with room to spare
   localparam int unsigned SETTLE_CYCLES = 100;
   // clearing sweep after reset plus a slow, heavily stalled run, several times over
   localparam int unsigned CYCLE_LIMIT   = 1500000;
   localparam int unsigned HOLD_CYCLES   = 400;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       is_crc;
      logic       last;
      logic       no_device;
   } pack_answer_type;

   typedef enum int unsigned {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_RAMP} fill_kind_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic       csr_index;
   logic [3:0] csr_write_data;

   cpac_req_if req_bus ();
   cpac_rsp_if rsp_bus ();

   controller_pack_access_crc_unit #(
      .PACK_BYTES(PACK_BYTES),
      .PORT_COUNT(PORT_COUNT)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_chan        (req_bus),
      .rsp_chan        (rsp_bus)
   );

   // Shadow of the engine: pack contents, configuration, write in progress
   bit   [7:0]   pack_image [0:PORT_COUNT*PACK_BYTES-1];
   logic [3:0]   present_bits = 4'h0;
   logic [3:0]   pak_bits     = 4'h0;
   int unsigned  wr_count     = 0;
   logic [15:0]  wr_base      = 16'h0000;
   logic [1:0]   wr_port      = 2'd0;
   logic [7:0]   wr_crc       = 8'h00;

   pack_answer_type pack_answer_q [$];
   int unsigned  error_count     = 0;
   int unsigned  items_sent      = 0;
   int unsigned  burst_left      = 0;
   bit           sender_gaps_on  = 1'b1;
   int unsigned  rsp_hold_request = 0;
   int unsigned  cycle_count     = 0;

   // Clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers outstanding",
                  cycle_count, pack_answer_q.size());
         $display("status: fail");
         $finish;
      end
   end

   // CRC-8, poly 0x85, one byte shifted in MSB first
   function automatic logic [7:0] crc8_fold(input logic [7:0] crc_in, input logic [7:0] data);
      logic [7:0] c;
      logic       fb;
      c = crc_in;
      for (int b = 7; b >= 0; b--) begin
         fb = c[7];
         c  = {c[6:0], data[b]};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // Block is backed by the pack: not the odd address, not past the top
   function automatic bit block_in_pack(input logic [15:0] addr);
      logic [15:0] base;
      base = addr & ADDR_ALIGN;
      return (addr != ADDR_SPECIAL) && (base <= ADDR_TOP) &&
             (32'(base) + BLOCK_BYTES <= PACK_BYTES);
   endfunction

   function automatic pack_answer_type answer(input logic [7:0] b, input logic crc,
                                              input logic last, input logic nodev);
      pack_answer_type a;
      a.byte_out  = b;
      a.is_crc    = crc;
      a.last      = last;
      a.no_device = nodev;
      return a;
   endfunction

   // Work out the answers one accepted transaction causes
   task automatic compute_pack_answers(input logic op, input logic [1:0] port,
                                       input logic [15:0] addr, input logic [7:0] data);
      logic [7:0]  crc;
      logic [7:0]  b;
      bit          from_pack;
      int unsigned base;
      if (op == OP_READ) begin
         // a read drops any partial write
         wr_count = 0;
         wr_crc   = 8'h00;
         if (!present_bits[port]) begin
            pack_answer_q.push_back(answer(8'h00, 1'b0, 1'b1, 1'b1));
            return;
         end
         from_pack = pak_bits[port] && block_in_pack(addr);
         base      = 32'(port) * PACK_BYTES + 32'(addr & ADDR_ALIGN);
         crc       = 8'h00;
         for (int i = 0; i < BLOCK_BYTES; i++) begin
            b   = from_pack ? pack_image[base + i] : 8'h00;
            crc = crc8_fold(crc, b);
            pack_answer_q.push_back(answer(b, 1'b0, 1'b0, 1'b0));
         end
         pack_answer_q.push_back(answer(crc8_fold(crc, 8'h00), 1'b1, 1'b1, 1'b0));
         return;
      end
      // write: first byte of a block latches port and address
      if (wr_count == 0) begin
         wr_base = addr;
         wr_port = port;
         wr_crc  = 8'h00;
      end
      if (present_bits[wr_port] && pak_bits[wr_port] && block_in_pack(wr_base)) begin
         pack_image[32'(wr_port) * PACK_BYTES + 32'(wr_base & ADDR_ALIGN) + wr_count] = data;
      end
      wr_crc = crc8_fold(wr_crc, data);
      wr_count++;
      if (wr_count == BLOCK_BYTES) begin
         wr_count = 0;
         if (!present_bits[wr_port]) begin
            pack_answer_q.push_back(answer(8'h00, 1'b0, 1'b1, 1'b1));
         end else begin
            pack_answer_q.push_back(answer(crc8_fold(wr_crc, 8'h00), 1'b1, 1'b1, 1'b0));
         end
      end
   endtask

   // Offer one request transaction; bursts with random gaps when enabled
   task automatic send_item(input logic op, input logic [1:0] port,
                            input logic [15:0] addr, input logic [7:0] data);
      int unsigned gap;
      if (sender_gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_bus.valid     = 1'b1;
      req_bus.operation = op;
      req_bus.port      = port;
      req_bus.address   = addr;
      req_bus.data_byte = data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      compute_pack_answers(op, port, addr, data);
      items_sent++;
      if (burst_left != 0) begin
         burst_left--;
      end
   endtask

   task automatic send_read_cmd(input logic [1:0] port, input logic [15:0] addr);
      send_item(OP_READ, port, addr, 8'($urandom));
   endtask

   // n data transactions of a write; only the first carries port and address
   task automatic send_write_cmd(input logic [1:0] port, input logic [15:0] addr,
                                 input int unsigned n, input fill_kind_type fill);
      logic [7:0] d;
      for (int i = 0; i < n; i++) begin
         case (fill)
            FILL_ZERO: d = 8'h00;
            FILL_ONES: d = 8'hFF;
            FILL_RAMP: d = 8'(i * 9 + 3);
            default:   d = 8'($urandom);
         endcase
         if (i == 0) begin
            send_item(OP_WRITE, port, addr, d);
         end else begin
            send_item(OP_WRITE, 2'($urandom), 16'($urandom), d);
         end
      end
   endtask

   // Stop offering, wait for every answer, then let the engine settle
   task automatic wait_engine_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pack_answer_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [3:0] value);
      wait_engine_idle();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (idx == CSR_PRESENT_MASK) begin
         present_bits = value;
      end else begin
         pak_bits = value;
      end
   endtask

   // Mostly blocks that get written and read again, some odd addresses
   function automatic logic [15:0] pick_address();
      logic [15:0] hot [8];
      hot = '{16'h0000, 16'h0020, 16'h1240, 16'h7FE0, 16'h4000, 16'h2AA0, 16'h5560, 16'h7FC0};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return hot[$urandom_range(0, 7)] | 16'($urandom_range(0, 31));
         6:                return ADDR_SPECIAL;
         7:                return 16'h8000 | 16'($urandom_range(0, 32767));
         8:                return 16'($urandom);
         default:          return 16'hFFE0 | 16'($urandom_range(0, 31));
      endcase
   endfunction

   // Receiver: own stall pattern, long hold-off on request
   initial begin
      int unsigned hold_left;
      int unsigned mode;
      int unsigned mode_left;
      int unsigned phase;
      logic [31:0] stall_pattern;
      hold_left     = 0;
      mode          = 0;
      mode_left     = 0;
      phase         = 0;
      stall_pattern = 32'h1;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request != 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode          = $urandom_range(0, 2);
               mode_left     = $urandom_range(20, 300);
               stall_pattern = $urandom | 32'h1;
            end
            mode_left--;
            phase = (phase + 1) % 32;
            case (mode)
               0:       rsp_bus.ready = 1'b1;
               1:       rsp_bus.ready = ($urandom_range(0, 99) < 60);
               default: rsp_bus.ready = stall_pattern[phase];
            endcase
         end
      end
   end

   // Check each answer transaction against the oldest prediction
   always @(posedge clock) begin : check_answers
      pack_answer_type got;
      pack_answer_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = answer(rsp_bus.byte_out, rsp_bus.is_crc, rsp_bus.last, rsp_bus.no_device);
         if (pack_answer_q.size() == 0) begin
            if (error_count < 10) begin
               $display("unexpected answer: byte %02h crc %b last %b nodev %b",
                        got.byte_out, got.is_crc, got.last, got.no_device);
            end
            error_count++;
         end else begin
            want = pack_answer_q.pop_front();
            if (got !== want) begin
               if (error_count < 10) begin
                  $display("mismatch at cycle %0d: expected byte %02h crc %b last %b nodev %b,",
                           cycle_count, want.byte_out, want.is_crc, want.last,
                           want.no_device);
                  $display("   got byte %02h crc %b last %b nodev %b",
                           got.byte_out, got.is_crc, got.last, got.no_device);
               end
               error_count++;
            end
         end
      end
   end

   // Nothing present after reset: every command answers no_device
   task automatic test_absent_after_reset();
      send_read_cmd(2'd0, 16'h0000);
      send_write_cmd(2'd3, 16'h1234, BLOCK_BYTES, FILL_RANDOM);
      send_read_cmd(2'd3, 16'h1234);
   endtask

   // Store blocks on every port and read them back, unaligned reads included
   task automatic test_block_roundtrip();
      write_csr(CSR_PRESENT_MASK, 4'hF);
      write_csr(CSR_PAK_MASK, 4'hF);
      send_write_cmd(2'd0, 16'h0000, BLOCK_BYTES, FILL_ZERO);
      send_write_cmd(2'd1, 16'h0020, BLOCK_BYTES, FILL_ONES);
      send_write_cmd(2'd2, 16'h7FE0, BLOCK_BYTES, FILL_RAMP);
      send_write_cmd(2'd3, 16'h125F, BLOCK_BYTES, FILL_RANDOM);
      send_read_cmd(2'd1, 16'h003F);
      send_read_cmd(2'd2, 16'h7FFF);
      send_read_cmd(2'd3, 16'h1240);
      send_read_cmd(2'd0, 16'h0000);
   endtask

   // Odd address and blocks above the top: zeros read, nothing stored
   task automatic test_out_of_range();
      send_write_cmd(2'd1, ADDR_SPECIAL, BLOCK_BYTES, FILL_RANDOM);
      send_read_cmd(2'd1, ADDR_SPECIAL);
      send_write_cmd(2'd0, 16'hFFE0, BLOCK_BYTES, FILL_ONES);
      send_read_cmd(2'd0, 16'hFFFF);
      send_read_cmd(2'd0, 16'h8000);
      send_read_cmd(2'd2, 16'h7FE0);
   endtask

   // Controller present without a pack: zero data, writes still answer a CRC
   task automatic test_missing_pack();
      write_csr(CSR_PAK_MASK, 4'h5);
      send_read_cmd(2'd1, 16'h0020);
      send_write_cmd(2'd3, 16'h0040, BLOCK_BYTES, FILL_RANDOM);
      write_csr(CSR_PAK_MASK, 4'hF);
      send_read_cmd(2'd3, 16'h0040);
   endtask

   // Some ports without a controller
   task automatic test_absent_ports();
      write_csr(CSR_PRESENT_MASK, 4'hA);
      send_read_cmd(2'd0, 16'h0000);
      send_write_cmd(2'd2, 16'h0060, BLOCK_BYTES, FILL_RANDOM);
      send_read_cmd(2'd1, 16'h0020);
      write_csr(CSR_PRESENT_MASK, 4'hF);
   endtask

   // A read in the middle of a write drops the rest of it
   task automatic test_abandoned_write();
      send_write_cmd(2'd0, 16'h0060, 10, FILL_RAMP);
      send_read_cmd(2'd0, 16'h0060);
      send_write_cmd(2'd0, 16'h0060, BLOCK_BYTES, FILL_RANDOM);
      send_read_cmd(2'd0, 16'h0060);
   endtask

   // Registers change halfway through a write
   task automatic test_config_mid_write();
      send_write_cmd(2'd2, 16'h0100, 16, FILL_RANDOM);
      write_csr(CSR_PAK_MASK, 4'hB);
      send_write_cmd(2'd1, 16'hFFFF, 16, FILL_RANDOM);
      write_csr(CSR_PAK_MASK, 4'hF);
      send_read_cmd(2'd2, 16'h0100);
      send_write_cmd(2'd1, 16'h0140, 16, FILL_RANDOM);
      write_csr(CSR_PRESENT_MASK, 4'hD);
      send_write_cmd(2'd0, 16'h0000, 16, FILL_RANDOM);
      write_csr(CSR_PRESENT_MASK, 4'hF);
      send_read_cmd(2'd1, 16'h0140);
   endtask

   // Receiver holds off while requests keep coming, so the input stalls
   task automatic test_output_backpressure();
      wait_engine_idle();
      sender_gaps_on   = 1'b0;
      rsp_hold_request = HOLD_CYCLES;
      send_read_cmd(2'd0, 16'h0000);
      send_read_cmd(2'd1, 16'h0020);
      send_write_cmd(2'd3, 16'h0200, BLOCK_BYTES, FILL_RANDOM);
      send_read_cmd(2'd3, 16'h0200);
      send_read_cmd(2'd2, 16'h7FE0);
      wait_engine_idle();
      sender_gaps_on = 1'b1;
   endtask

   // Random commands under one register setting, kept within the item budget
   task automatic run_random_phase(input logic [3:0] present, input logic [3:0] pak,
                                   input int unsigned n_items);
      int unsigned start;
      int unsigned pick;
      int unsigned room;
      write_csr(CSR_PRESENT_MASK, present);
      write_csr(CSR_PAK_MASK, pak);
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      start          = items_sent;
      while (items_sent - start < n_items) begin
         room = n_items - (items_sent - start);
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            send_read_cmd(2'($urandom), pick_address());
         end else if (pick < 90 && room >= BLOCK_BYTES) begin
            send_write_cmd(2'($urandom), pick_address(), BLOCK_BYTES, FILL_RANDOM);
         end else begin
            // partial block: abandoned by a read or merged into the next write
            send_write_cmd(2'($urandom), pick_address(),
                           $urandom_range(1, (room < 31) ? room : 31), FILL_RANDOM);
         end
      end
      sender_gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      run_random_phase(4'hF, 4'hF, 32);
      run_random_phase(4'hF, 4'h0, 8);
      run_random_phase(4'h0, 4'hF, 8);
      run_random_phase(4'($urandom), 4'($urandom), 8);
      run_random_phase(4'hF, 4'hF, 8);
   endtask

   // Test sequence
   initial begin
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_PRESENT_MASK;
      csr_write_data    = 4'h0;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_READ;
      req_bus.port      = 2'd0;
      req_bus.address   = 16'h0000;
      req_bus.data_byte = 8'h00;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_absent_after_reset();
      test_block_roundtrip();
      test_out_of_range();
      test_missing_pack();
      test_absent_ports();
      test_abandoned_write();
      test_config_mid_write();
      test_output_backpressure();
      test_random_traffic();

      wait_engine_idle();
      if (pack_answer_q.size() != 0) begin
         $display("%0d answers never arrived", pack_answer_q.size());
         error_count += pack_answer_q.size();
      end
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
